// ===== hdl/clc_pkg.sv =====
// ----------------------------------------------------------------------------
// clc_pkg
// Shared types and constants for the circular list cursor engine: request
// codes, status codes, field widths and the control bundles between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package clc_pkg;

   // fixed field widths of the request and response channels
   localparam int OP_BITS          = 2;
   localparam int VALUE_FIELD_BITS = 16;
   localparam int SKIP_BITS        = 6;
   localparam int COUNT_FIELD_BITS = 5;
   localparam int STATUS_BITS      = 2;

   // default sizing
   localparam int DEFAULT_CAPACITY   = 16;
   localparam int DEFAULT_VALUE_BITS = 16;

   // free-slot search looks at this many slots per cycle
   localparam int SCAN_CHUNK = 16;

   // request operation codes
   localparam logic [OP_BITS-1:0] OP_INSERT     = 2'd0;
   localparam logic [OP_BITS-1:0] OP_DELETE     = 2'd1;
   localparam logic [OP_BITS-1:0] OP_STEP_RIGHT = 2'd2;
   localparam logic [OP_BITS-1:0] OP_STEP_LEFT  = 2'd3;

   // response status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

   // link memory field write enables
   typedef struct packed {
      logic we_right;
      logic we_left;
   } link_wr_type;

   // slot allocator controls
   typedef struct packed {
      logic scan;       // start a lowest-free-slot search
      logic free_one;   // free one slot
      logic clear_all;  // free every slot
   } alloc_ctrl_type;

endpackage

`default_nettype wire

// ===== hdl/circular_list_cursor_engine.sv =====
// A refused request goes straight to the response; an insert first waits for the
// free-slot search, and a delete walks skip_count steps before it unlinks.
// One request in flight: the next is taken from the cycle after the response loads.
// A finished response waits in the output register while the next request is taken.
// Reset (synchronous) clears cursor, head, count and the slot bitmap;
// the value and link memories are not cleared.
// ----------------------------------------------------------------------------
// circular_list_cursor_engine
// Doubly linked circular ring held in a value memory and a link memory, with
// a cursor and a head mark. Insert after cursor, delete at cursor, or walk the
// cursor right or left and then delete.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_list_cursor_engine
   import clc_pkg::*;
#(
   parameter int CAPACITY   = DEFAULT_CAPACITY,
   parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [OP_BITS-1:0]          req_operation,
   input  wire logic [VALUE_FIELD_BITS-1:0] req_value,
   input  wire logic [SKIP_BITS-1:0]        req_skip_count,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic      [VALUE_FIELD_BITS-1:0] rsp_removed_value,
   output logic      [VALUE_FIELD_BITS-1:0] rsp_cursor_value,
   output logic      [VALUE_FIELD_BITS-1:0] rsp_head_value,
   output logic      [COUNT_FIELD_BITS-1:0] rsp_entry_count,
   output logic      [STATUS_BITS-1:0]      rsp_status
);

   localparam int SLOT_BITS  = $clog2(CAPACITY);
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);

   // sequencer states
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_SCAN    = 4'd1;
   localparam logic [3:0] S_INS_W1  = 4'd2;
   localparam logic [3:0] S_INS_W2  = 4'd3;
   localparam logic [3:0] S_INS_W3  = 4'd4;
   localparam logic [3:0] S_DEL_RD  = 4'd5;
   localparam logic [3:0] S_DEL_CHK = 4'd6;
   localparam logic [3:0] S_DEL_W1  = 4'd7;
   localparam logic [3:0] S_DEL_W2  = 4'd8;
   localparam logic [3:0] S_FIN     = 4'd9;
   localparam logic [3:0] S_OUT     = 4'd10;

   logic [3:0]            state_ff, state_in;
   logic [OP_BITS-1:0]    op_ff, op_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [SKIP_BITS-1:0]  steps_ff, steps_in;
   logic [SLOT_BITS-1:0]  cursor_ff, cursor_in;
   logic [SLOT_BITS-1:0]  head_ff, head_in;
   logic [COUNT_BITS-1:0] size_ff, size_in;
   logic [SLOT_BITS-1:0]  walk_ff, walk_in;
   logic [SLOT_BITS-1:0]  new_ff, new_in;
   logic [SLOT_BITS-1:0]  left_ff, left_in;
   logic [SLOT_BITS-1:0]  right_ff, right_in;
   logic [VALUE_BITS-1:0] removed_ff, removed_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [VALUE_FIELD_BITS-1:0] rsp_removed_ff, rsp_removed_in;
   logic [VALUE_FIELD_BITS-1:0] rsp_cursor_ff, rsp_cursor_in;
   logic [VALUE_FIELD_BITS-1:0] rsp_head_ff, rsp_head_in;
   logic [COUNT_FIELD_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic [STATUS_BITS-1:0]      rsp_status_ff, rsp_status_in;

   // memory and allocator hookup
   link_wr_type           link_wr;
   logic [SLOT_BITS-1:0]  link_wr_addr, link_wr_right, link_wr_left;
   logic [SLOT_BITS-1:0]  rd_addr;
   logic [SLOT_BITS-1:0]  rd_right, rd_left;
   logic                  val_wr_en;
   logic [VALUE_BITS-1:0] val_rd_a, val_rd_b;
   alloc_ctrl_type        alloc_ctrl;
   logic                  alloc_found;
   logic [SLOT_BITS-1:0]  alloc_slot;
   logic                  req_fire, rsp_free;

   clc_link_ram #(
      .DEPTH     (CAPACITY),
      .SLOT_BITS (SLOT_BITS)
   ) u_link_ram (
      .clock    (clock),
      .wr       (link_wr),
      .wr_addr  (link_wr_addr),
      .wr_right (link_wr_right),
      .wr_left  (link_wr_left),
      .rd_addr  (rd_addr),
      .rd_right (rd_right),
      .rd_left  (rd_left)
   );

   // value written only when a fresh slot comes out of the search
   clc_value_ram #(
      .DEPTH      (CAPACITY),
      .SLOT_BITS  (SLOT_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_value_ram (
      .clock     (clock),
      .wr_en     (val_wr_en),
      .wr_addr   (alloc_slot),
      .wr_data   (value_ff),
      .rd_a_addr (rd_addr),
      .rd_a_data (val_rd_a),
      .rd_b_addr (head_ff),
      .rd_b_data (val_rd_b)
   );

   clc_slot_alloc #(
      .CAPACITY  (CAPACITY),
      .SLOT_BITS (SLOT_BITS)
   ) u_slot_alloc (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (alloc_ctrl),
      .release_slot (walk_ff),
      .found        (alloc_found),
      .found_slot   (alloc_slot)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign rsp_free  = ~rsp_valid_ff | rsp_ready;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      value_in   = value_ff;
      steps_in   = steps_ff;
      cursor_in  = cursor_ff;
      head_in    = head_ff;
      size_in    = size_ff;
      walk_in    = walk_ff;
      new_in     = new_ff;
      left_in    = left_ff;
      right_in   = right_ff;
      removed_in = removed_ff;
      status_in  = status_ff;

      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      rsp_removed_in = rsp_removed_ff;
      rsp_cursor_in  = rsp_cursor_ff;
      rsp_head_in    = rsp_head_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_status_in  = rsp_status_ff;

      link_wr       = '0;
      link_wr_addr  = cursor_ff;
      link_wr_right = '0;
      link_wr_left  = '0;
      rd_addr       = cursor_ff;
      val_wr_en     = 1'b0;
      alloc_ctrl    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in      = req_operation;
               value_in   = VALUE_BITS'(req_value);
               removed_in = '0;
               status_in  = STATUS_OK;
               walk_in    = cursor_ff;
               steps_in   = (req_operation == OP_STEP_RIGHT ||
                             req_operation == OP_STEP_LEFT) ? req_skip_count : '0;
               if (req_operation == OP_INSERT) begin
                  if (size_ff == COUNT_BITS'(CAPACITY)) begin
                     status_in = STATUS_FULL;
                     state_in  = S_FIN;
                  end else begin
                     alloc_ctrl.scan = 1'b1;
                     state_in        = S_SCAN;
                  end
               end else if (size_ff == '0) begin
                  status_in = STATUS_EMPTY;
                  state_in  = S_FIN;
               end else begin
                  state_in = S_DEL_RD;
               end
            end
         end

         // wait for a free slot; link read of the cursor runs meanwhile
         S_SCAN: begin
            if (alloc_found) begin
               new_in    = alloc_slot;
               val_wr_en = 1'b1;
               if (size_ff == '0) begin
                  link_wr       = '{we_right: 1'b1, we_left: 1'b1};
                  link_wr_addr  = alloc_slot;
                  link_wr_right = alloc_slot;
                  link_wr_left  = alloc_slot;
                  head_in       = alloc_slot;
                  cursor_in     = alloc_slot;
                  size_in       = size_ff + 1'b1;
                  state_in      = S_FIN;
               end else begin
                  state_in = S_INS_W1;
               end
            end
         end

         // new entry links to cursor and its old right neighbor
         S_INS_W1: begin
            right_in      = rd_right;
            link_wr       = '{we_right: 1'b1, we_left: 1'b1};
            link_wr_addr  = new_ff;
            link_wr_right = rd_right;
            link_wr_left  = cursor_ff;
            state_in      = S_INS_W2;
         end

         S_INS_W2: begin
            link_wr      = '{we_right: 1'b0, we_left: 1'b1};
            link_wr_addr = right_ff;
            link_wr_left = new_ff;
            state_in     = S_INS_W3;
         end

         S_INS_W3: begin
            link_wr       = '{we_right: 1'b1, we_left: 1'b0};
            link_wr_addr  = cursor_ff;
            link_wr_right = new_ff;
            cursor_in     = new_ff;
            size_in       = size_ff + 1'b1;
            state_in      = S_FIN;
         end

         S_DEL_RD: begin
            rd_addr  = walk_ff;
            state_in = S_DEL_CHK;
         end

         // one step per cycle: read data picks the next address
         S_DEL_CHK: begin
            if (steps_ff != '0) begin
               walk_in  = (op_ff == OP_STEP_RIGHT) ? rd_right : rd_left;
               rd_addr  = walk_in;
               steps_in = steps_ff - 1'b1;
            end else begin
               removed_in = val_rd_a;
               left_in    = rd_left;
               right_in   = rd_right;
               state_in   = S_DEL_W1;
            end
         end

         S_DEL_W1: begin
            link_wr       = '{we_right: 1'b1, we_left: 1'b0};
            link_wr_addr  = left_ff;
            link_wr_right = right_ff;
            state_in      = S_DEL_W2;
         end

         S_DEL_W2: begin
            link_wr             = '{we_right: 1'b0, we_left: 1'b1};
            link_wr_addr        = right_ff;
            link_wr_left        = left_ff;
            alloc_ctrl.free_one = 1'b1;
            cursor_in           = right_ff;
            size_in             = size_ff - 1'b1;
            if (walk_ff == head_ff) begin
               head_in = right_ff;
            end
            // last entry gone: ring returns to its reset shape
            if (size_ff == COUNT_BITS'(1)) begin
               alloc_ctrl.clear_all = 1'b1;
               cursor_in            = '0;
               head_in              = '0;
            end
            state_in = S_FIN;
         end

         // cursor on port A, head on port B
         S_FIN: begin
            state_in = S_OUT;
         end

         S_OUT: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_removed_in = VALUE_FIELD_BITS'(removed_ff);
               rsp_cursor_in  = (size_ff != '0) ? VALUE_FIELD_BITS'(val_rd_a) : '0;
               rsp_head_in    = (size_ff != '0) ? VALUE_FIELD_BITS'(val_rd_b) : '0;
               rsp_count_in   = COUNT_FIELD_BITS'(size_ff);
               rsp_status_in  = status_ff;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cursor_ff    <= '0;
         head_ff      <= '0;
         size_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         head_ff      <= head_in;
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request working registers and response payload
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      value_ff       <= value_in;
      steps_ff       <= steps_in;
      walk_ff        <= walk_in;
      new_ff         <= new_in;
      left_ff        <= left_in;
      right_ff       <= right_in;
      removed_ff     <= removed_in;
      status_ff      <= status_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_cursor_ff  <= rsp_cursor_in;
      rsp_head_ff    <= rsp_head_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_cursor_value  = rsp_cursor_ff;
   assign rsp_head_value    = rsp_head_ff;
   assign rsp_entry_count   = rsp_count_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

`default_nettype wire

// ===== hdl/clc_link_ram.sv =====
// ----------------------------------------------------------------------------
// clc_link_ram
// Link memory: one word per slot holding the right and left links, with a
// separate write enable per link field and a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module clc_link_ram
   import clc_pkg::*;
#(
   parameter int DEPTH     = DEFAULT_CAPACITY,
   parameter int SLOT_BITS = $clog2(DEFAULT_CAPACITY)
) (
   input  wire logic                 clock,
   input  wire link_wr_type          wr,
   input  wire logic [SLOT_BITS-1:0] wr_addr,
   input  wire logic [SLOT_BITS-1:0] wr_right,
   input  wire logic [SLOT_BITS-1:0] wr_left,
   input  wire logic [SLOT_BITS-1:0] rd_addr,
   output logic      [SLOT_BITS-1:0] rd_right,
   output logic      [SLOT_BITS-1:0] rd_left
);

   // word layout: right link in the upper half, left link in the lower half
   logic [2*SLOT_BITS-1:0] link_mem [DEPTH];
   logic [2*SLOT_BITS-1:0] rd_data_ff;

   // masked write, registered read
   always_ff @(posedge clock) begin
      if (wr.we_right) begin
         link_mem[wr_addr][2*SLOT_BITS-1:SLOT_BITS] <= wr_right;
      end
      if (wr.we_left) begin
         link_mem[wr_addr][SLOT_BITS-1:0] <= wr_left;
      end
      rd_data_ff <= link_mem[rd_addr];
   end

   assign rd_right = rd_data_ff[2*SLOT_BITS-1:SLOT_BITS];
   assign rd_left  = rd_data_ff[SLOT_BITS-1:0];

endmodule

`default_nettype wire

// ===== hdl/clc_value_ram.sv =====
// ----------------------------------------------------------------------------
// clc_value_ram
// Value memory: one value per slot, one write port and two registered read
// ports (cursor side and head side).
// ----------------------------------------------------------------------------
`default_nettype none

module clc_value_ram
   import clc_pkg::*;
#(
   parameter int DEPTH      = DEFAULT_CAPACITY,
   parameter int SLOT_BITS  = $clog2(DEFAULT_CAPACITY),
   parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [SLOT_BITS-1:0]  wr_addr,
   input  wire logic [VALUE_BITS-1:0] wr_data,
   input  wire logic [SLOT_BITS-1:0]  rd_a_addr,
   output logic      [VALUE_BITS-1:0] rd_a_data,
   input  wire logic [SLOT_BITS-1:0]  rd_b_addr,
   output logic      [VALUE_BITS-1:0] rd_b_data
);

   logic [VALUE_BITS-1:0] value_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         value_mem[wr_addr] <= wr_data;
      end
      rd_a_data <= value_mem[rd_a_addr];
      rd_b_data <= value_mem[rd_b_addr];
   end

endmodule

`default_nettype wire

// ===== hdl/clc_slot_alloc.sv =====
// ----------------------------------------------------------------------------
// clc_slot_alloc
// Slot occupancy bitmap with a chunked search for the lowest free slot. The
// slot found is marked in use in the same cycle it is reported.
// ----------------------------------------------------------------------------
`default_nettype none

module clc_slot_alloc
   import clc_pkg::*;
#(
   parameter int CAPACITY  = DEFAULT_CAPACITY,
   parameter int SLOT_BITS = $clog2(DEFAULT_CAPACITY)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire alloc_ctrl_type       ctrl,
   input  wire logic [SLOT_BITS-1:0] release_slot,
   output logic                      found,
   output logic      [SLOT_BITS-1:0] found_slot
);

   localparam int CHUNK          = (CAPACITY < SCAN_CHUNK) ? CAPACITY : SCAN_CHUNK;
   localparam int NUM_CHUNKS     = (CAPACITY + CHUNK - 1) / CHUNK;
   localparam int CHUNK_SEL_BITS = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
   localparam int PAD_BITS       = NUM_CHUNKS * CHUNK;
   localparam int IDX_BITS       = (CHUNK > 1) ? $clog2(CHUNK) : 1;

   logic [CAPACITY-1:0]       in_use_ff, in_use_in;
   logic                      busy_ff, busy_in;
   logic [CHUNK_SEL_BITS-1:0] chunk_ff, chunk_in;
   logic [PAD_BITS-1:0]       padded;
   logic [CHUNK-1:0]          chunk_bits;
   logic                      hit;
   logic [IDX_BITS-1:0]       hit_idx;

   // slots past the capacity read as taken
   always_comb begin
      padded                 = '1;
      padded[CAPACITY-1:0]   = in_use_ff;
      chunk_bits             = padded[int'(chunk_ff) * CHUNK +: CHUNK];
   end

   // lowest clear bit of the current chunk
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = CHUNK - 1; i >= 0; i--) begin
         if (!chunk_bits[i]) begin
            hit     = 1'b1;
            hit_idx = IDX_BITS'(i);
         end
      end
   end

   assign found      = busy_ff & hit;
   assign found_slot = SLOT_BITS'(int'(chunk_ff) * CHUNK + int'(hit_idx));

   // bitmap update and search sequencing
   always_comb begin
      in_use_in = in_use_ff;
      if (found) begin
         in_use_in[found_slot] = 1'b1;
      end
      if (ctrl.free_one) begin
         in_use_in[release_slot] = 1'b0;
      end
      if (ctrl.clear_all) begin
         in_use_in = '0;
      end

      busy_in  = busy_ff;
      chunk_in = chunk_ff;
      if (ctrl.scan) begin
         busy_in  = 1'b1;
         chunk_in = '0;
      end else if (found) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         chunk_in = (chunk_ff == CHUNK_SEL_BITS'(NUM_CHUNKS - 1)) ? '0 : chunk_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= '0;
         busy_ff   <= 1'b0;
         chunk_ff  <= '0;
      end else begin
         in_use_ff <= in_use_in;
         busy_ff   <= busy_in;
         chunk_ff  <= chunk_in;
      end
   end

endmodule

`default_nettype wire

// ===== tb/circular_list_cursor_engine_tb.sv =====
// ----------------------------------------------------------------------------
// circular_list_cursor_engine_tb
// Self-checking bench for the circular list cursor engine. A short directed
// table covers the empty ring, the first insert, emptying, filling, the full
// ring and the longest cursor walks. After that come random requests that fill
// and drain the ring in turn, under several sender and receiver idle patterns.
// Each response is checked against its directed row or a ring predictor in the bench.
// ----------------------------------------------------------------------------

module circular_list_cursor_engine_tb;
   import clc_pkg::*;

   localparam int RING_CAP      = DEFAULT_CAPACITY;
   localparam int RANDOM_ITEMS  = 1550;
   localparam int NUM_PHASES    = 4;
   localparam int LIMIT_CYCLES  = 1_000_000;
   localparam int DRAIN_CYCLES  = 100;
   localparam int DIR_ROWS      = 13;

   typedef struct packed {
      logic [VALUE_FIELD_BITS-1:0] removed;
      logic [VALUE_FIELD_BITS-1:0] cursor;
      logic [VALUE_FIELD_BITS-1:0] head;
      logic [COUNT_FIELD_BITS-1:0] count;
      logic [STATUS_BITS-1:0]      status;
   } ring_rsp_type;

   // one directed row; value advances by one on each repeat
   typedef struct packed {
      logic [OP_BITS-1:0]          op;
      logic [VALUE_FIELD_BITS-1:0] value;
      logic [SKIP_BITS-1:0]        skip;
      logic [4:0]                  reps;
      logic                        fixed;
      ring_rsp_type                rsp;
   } dir_row_type;

   dir_row_type dir_table [DIR_ROWS] = '{
      '{OP_DELETE,     16'h0000,  6'd0, 5'd1,  1'b1, '{16'h0, 16'h0, 16'h0, 5'd0, STATUS_EMPTY}},
      '{OP_STEP_RIGHT, 16'hFFFF, 6'd63, 5'd1,  1'b1, '{16'h0, 16'h0, 16'h0, 5'd0, STATUS_EMPTY}},
      '{OP_STEP_LEFT,  16'h0000,  6'd0, 5'd1,  1'b1, '{16'h0, 16'h0, 16'h0, 5'd0, STATUS_EMPTY}},
      '{OP_INSERT,     16'hFFFF,  6'd0, 5'd1,  1'b1,
        '{16'h0, 16'hFFFF, 16'hFFFF, 5'd1, STATUS_OK}},
      '{OP_DELETE,     16'h0000, 6'd63, 5'd1,  1'b1, '{16'hFFFF, 16'h0, 16'h0, 5'd0, STATUS_OK}},
      '{OP_INSERT,     16'h0000,  6'd0, 5'd1,  1'b1, '{16'h0, 16'h0, 16'h0, 5'd1, STATUS_OK}},
      '{OP_INSERT,     16'h8000,  6'd0, 5'd15, 1'b0, '0},
      '{OP_INSERT,     16'h5A5A, 6'd21, 5'd1,  1'b1,
        '{16'h0, 16'h800E, 16'h0000, 5'd16, STATUS_FULL}},
      '{OP_STEP_RIGHT, 16'h0000, 6'd63, 5'd1,  1'b0, '0},
      '{OP_STEP_LEFT,  16'h0000, 6'd63, 5'd1,  1'b0, '0},
      '{OP_STEP_LEFT,  16'h0000,  6'd0, 5'd1,  1'b0, '0},
      '{OP_STEP_RIGHT, 16'h0000,  6'd0, 5'd1,  1'b0, '0},
      '{OP_DELETE,     16'h0000,  6'd0, 5'd1,  1'b0, '0}
   };

   logic                        clock          = 1'b0;
   logic                        reset          = 1'b1;
   logic                        req_valid      = 1'b0;
   logic                        req_ready;
   logic [OP_BITS-1:0]          req_operation  = OP_INSERT;
   logic [VALUE_FIELD_BITS-1:0] req_value      = '0;
   logic [SKIP_BITS-1:0]        req_skip_count = '0;
   logic                        rsp_valid;
   logic                        rsp_ready      = 1'b0;
   logic [VALUE_FIELD_BITS-1:0] rsp_removed_value;
   logic [VALUE_FIELD_BITS-1:0] rsp_cursor_value;
   logic [VALUE_FIELD_BITS-1:0] rsp_head_value;
   logic [COUNT_FIELD_BITS-1:0] rsp_entry_count;
   logic [STATUS_BITS-1:0]      rsp_status;

   // ring copy held by the bench
   logic [VALUE_FIELD_BITS-1:0] slot_val   [RING_CAP];
   logic [3:0]                  right_of   [RING_CAP];
   logic [3:0]                  left_of    [RING_CAP];
   logic [RING_CAP-1:0]         slot_busy  = '0;
   logic [3:0]                  cur_slot   = '0;
   logic [3:0]                  head_mark  = '0;
   int                          ring_len   = 0;

   ring_rsp_type pending_ring_rsps [$];
   int        error_count = 0;
   int        cycle_count = 0;
   int        send_idle_pct = 0;
   int        recv_stall_pct = 0;
   bit        fill_mode = 1'b1;

   circular_list_cursor_engine DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_value         (req_value),
      .req_skip_count    (req_skip_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_removed_value (rsp_removed_value),
      .rsp_cursor_value  (rsp_cursor_value),
      .rsp_head_value    (rsp_head_value),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_status        (rsp_status)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // applies one request to the bench ring and returns the response it gives
   function automatic ring_rsp_type ring_next_response(input logic [OP_BITS-1:0] op,
                                                       input logic [VALUE_FIELD_BITS-1:0] val,
                                                       input logic [SKIP_BITS-1:0] skip);
      ring_rsp_type r;
      logic [3:0] s;
      logic [3:0] c;
      logic [3:0] lft;
      logic [3:0] rgt;
      bit         found;
      r = '0;
      r.status = STATUS_OK;
      if (op == OP_INSERT) begin
         found = 1'b0;
         s = '0;
         for (int i = RING_CAP - 1; i >= 0; i--) begin
            if (!slot_busy[i]) begin
               s = i[3:0];
               found = 1'b1;
            end
         end
         if (ring_len >= RING_CAP || !found) begin
            r.status = STATUS_FULL;
         end else begin
            slot_busy[s] = 1'b1;
            slot_val[s] = val;
            if (ring_len == 0) begin
               right_of[s] = s;
               left_of[s] = s;
               head_mark = s;
            end else begin
               c = cur_slot;
               rgt = right_of[c];
               right_of[s] = rgt;
               left_of[s] = c;
               left_of[rgt] = s;
               right_of[c] = s;
            end
            cur_slot = s;
            ring_len++;
         end
      end else if (ring_len == 0) begin
         r.status = STATUS_EMPTY;
      end else begin
         // walk, then unlink
         c = cur_slot;
         for (int i = 0; i < skip; i++) begin
            if (op == OP_STEP_RIGHT) c = right_of[c];
            else if (op == OP_STEP_LEFT) c = left_of[c];
         end
         r.removed = slot_val[c];
         lft = left_of[c];
         rgt = right_of[c];
         if (c == head_mark) head_mark = rgt;
         right_of[lft] = rgt;
         left_of[rgt] = lft;
         slot_busy[c] = 1'b0;
         cur_slot = rgt;
         ring_len--;
         if (ring_len == 0) begin
            slot_busy = '0;
            cur_slot = '0;
            head_mark = '0;
         end
      end
      r.cursor = (ring_len != 0) ? slot_val[cur_slot] : '0;
      r.head = (ring_len != 0) ? slot_val[head_mark] : '0;
      r.count = ring_len[COUNT_FIELD_BITS-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at cycle %0d on %s: got %0h, expected %0h",
               cycle_count, what, got, want);
      error_count++;
   endtask

   // response checker
   always @(posedge clock) begin
      ring_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_ring_rsps.size() == 0) begin
            report_mismatch("unrequested response", 32'(rsp_status), 32'd0);
         end else begin
            want = pending_ring_rsps.pop_front();
            if (rsp_removed_value !== want.removed)
               report_mismatch("removed_value", 32'(rsp_removed_value), 32'(want.removed));
            if (rsp_cursor_value !== want.cursor)
               report_mismatch("cursor_value", 32'(rsp_cursor_value), 32'(want.cursor));
            if (rsp_head_value !== want.head)
               report_mismatch("head_value", 32'(rsp_head_value), 32'(want.head));
            if (rsp_entry_count !== want.count)
               report_mismatch("entry_count", 32'(rsp_entry_count), 32'(want.count));
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
         end
      end
   end

   // drives one request, waits for it to be taken and queues its response
   task automatic send_request(input logic [OP_BITS-1:0] op,
                               input logic [VALUE_FIELD_BITS-1:0] val,
                               input logic [SKIP_BITS-1:0] skip,
                               input bit use_fixed, input ring_rsp_type fixed_rsp);
      ring_rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_value <= val;
      req_skip_count <= skip;
      do @(posedge clock); while (!req_ready);
      predicted = ring_next_response(op, val, skip);
      pending_ring_rsps.push_back(use_fixed ? fixed_rsp : predicted);
   endtask

   // hold off until every queued response is back
   task automatic wait_ring_drained();
      if (pending_ring_rsps.size() != 0) begin
         req_valid <= 1'b0;
         while (pending_ring_rsps.size() != 0) @(posedge clock);
      end
   endtask

   // random request: alternates between filling and draining the ring
   task automatic send_random_request();
      logic [OP_BITS-1:0]          op;
      logic [VALUE_FIELD_BITS-1:0] val;
      logic [SKIP_BITS-1:0]        skip;
      if (ring_len == RING_CAP && $urandom_range(1) == 0) fill_mode = 1'b0;
      if (ring_len == 0 && $urandom_range(1) == 0) fill_mode = 1'b1;
      if ($urandom_range(39) == 0) fill_mode = !fill_mode;
      if ($urandom_range(99) < (fill_mode ? 75 : 25)) op = OP_INSERT;
      else op = OP_BITS'($urandom_range(3, 1));
      case ($urandom_range(3))
         0: val = VALUE_FIELD_BITS'($urandom_range(3));  // repeats make equal values likely
         1: val = $urandom_range(1) ? 16'hFFFF : 16'h0000;
         default: val = VALUE_FIELD_BITS'($urandom_range(16'hFFFF));
      endcase
      skip = ($urandom_range(3) == 0) ? SKIP_BITS'($urandom_range(3))
                                      : SKIP_BITS'($urandom_range(63));
      send_request(op, val, skip, 1'b0, '0);
   endtask

   initial begin
      int phase_idle [NUM_PHASES];
      int phase_stall [NUM_PHASES];
      int per_phase;
      phase_idle = '{0, 70, 0, 11};
      phase_stall = '{0, 0, 70, 11};
      per_phase = RANDOM_ITEMS / NUM_PHASES;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int r = 0; r < DIR_ROWS; r++) begin
         for (int k = 0; k < dir_table[r].reps; k++) begin
            send_request(dir_table[r].op, dir_table[r].value + k[VALUE_FIELD_BITS-1:0],
                         dir_table[r].skip, dir_table[r].fixed, dir_table[r].rsp);
         end
      end

      // random phases, each starting from an idle engine
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_ring_drained();
         send_idle_pct = phase_idle[p];
         recv_stall_pct = phase_stall[p];
         for (int n = 0; n < per_phase; n++) send_random_request();
      end

      req_valid <= 1'b0;
      while (pending_ring_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_ring_rsps.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
